// ----- hdl/bmpt_pkg.sv -----
// Shared types, constants and decode helpers for the bus mouse position tracker.
package bmpt_pkg;

    localparam int unsigned PosWidth      = 12;
    localparam int unsigned NibbleWidth   = 4;
    localparam int unsigned StatusWidth   = 8;
    localparam int unsigned DeltaWidth    = 8;
    localparam int unsigned CfgIndexWidth = 8;

    localparam logic [PosWidth-1:0] POS_RESET   = 12'd320;
    localparam logic [PosWidth-1:0] X_MIN_RESET = 12'd0;
    localparam logic [PosWidth-1:0] X_MAX_RESET = 12'd639;
    localparam logic [PosWidth-1:0] Y_MIN_RESET = 12'd0;
    localparam logic [PosWidth-1:0] Y_MAX_RESET = 12'd399;

    // Register indexes on the configuration port
    localparam logic [CfgIndexWidth-1:0] REG_X_MIN = 8'd0;
    localparam logic [CfgIndexWidth-1:0] REG_X_MAX = 8'd1;
    localparam logic [CfgIndexWidth-1:0] REG_Y_MIN = 8'd2;
    localparam logic [CfgIndexWidth-1:0] REG_Y_MAX = 8'd3;

    // Raw button field codes in status bits 7:5
    localparam logic [2:0] RAW_LEFT   = 3'd4;
    localparam logic [2:0] RAW_RIGHT  = 3'd1;
    localparam logic [2:0] RAW_MIDDLE = 3'd0;

    typedef enum logic [1:0] {
        BTN_NONE   = 2'd0,
        BTN_LEFT   = 2'd1,
        BTN_RIGHT  = 2'd2,
        BTN_MIDDLE = 2'd3
    } button_code_t;

    typedef struct packed {
        logic [NibbleWidth-1:0] x_low_nibble;
        logic [NibbleWidth-1:0] x_high_nibble;
        logic [NibbleWidth-1:0] y_low_nibble;
        logic [StatusWidth-1:0] status_byte;
    } in_item_t;

    typedef struct packed {
        logic [PosWidth-1:0] x_pos;
        logic [PosWidth-1:0] y_pos;
        logic [1:0]          button_code;
        logic                changed;
    } out_item_t;

    // Map the raw button field to a button code
    function automatic button_code_t decode_buttons(input logic [2:0] raw);
        button_code_t code;
        unique case (raw)
            RAW_LEFT:   code = BTN_LEFT;
            RAW_RIGHT:  code = BTN_RIGHT;
            RAW_MIDDLE: code = BTN_MIDDLE;
            default:    code = BTN_NONE;
        endcase
        return code;
    endfunction

    // Add a signed delta and clamp: minimum first, then maximum
    function automatic logic [PosWidth-1:0] move_clamp(
        input logic [PosWidth-1:0]   pos,
        input logic [DeltaWidth-1:0] delta,
        input logic [PosWidth-1:0]   lo,
        input logic [PosWidth-1:0]   hi
    );
        logic signed [PosWidth+1:0] sum;
        logic signed [PosWidth+1:0] lo_s;
        logic signed [PosWidth+1:0] hi_s;
        logic signed [PosWidth+1:0] val;
        sum  = $signed({2'b00, pos}) + (PosWidth+2)'($signed(delta));
        lo_s = $signed({2'b00, lo});
        hi_s = $signed({2'b00, hi});
        val  = sum;
        if (val < lo_s)
            val = lo_s;
        if (val > hi_s)
            val = hi_s;
        return val[PosWidth-1:0];
    endfunction

endpackage

// ----- hdl/bus_mouse_position_tracker_core.sv -----
// Bus mouse position tracker: input register, move-and-clamp logic, result register.
// A request passes from the input register through move-and-clamp into the result register.
// Throughput: one request per cycle while results are taken; the single move-and-clamp pass
// per axis between the input register and the result register sets that figure.
// The input register can take a new request while a finished one waits in the result register.
// Reset (rst_n low, asynchronous): position 320/320, button code none, box 0..639 x 0..399.
module bus_mouse_position_tracker_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  bmpt_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output bmpt_pkg::out_item_t                   out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bmpt_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [bmpt_pkg::PosWidth-1:0]         cfg_data
);

    logic                              in_valid_reg;
    bmpt_pkg::in_item_t                in_data_reg;
    logic                              out_valid_reg;
    bmpt_pkg::out_item_t               out_data_reg;
    logic [bmpt_pkg::PosWidth-1:0]     x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [bmpt_pkg::PosWidth-1:0]     pos_x_reg, pos_y_reg;
    bmpt_pkg::button_code_t            last_buttons_reg;

    logic                              advance;
    logic [bmpt_pkg::DeltaWidth-1:0]   delta_x, delta_y;
    logic                              moving;
    bmpt_pkg::button_code_t            button_next;
    logic [bmpt_pkg::PosWidth-1:0]     pos_x_next, pos_y_next;
    bmpt_pkg::out_item_t               out_data_next;

    // Move the held request forward when the result slot is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // Assemble deltas and compute the new position
    always_comb
    begin
        delta_x     = {in_data_reg.x_high_nibble, in_data_reg.x_low_nibble};
        delta_y     = {in_data_reg.status_byte[3:0], in_data_reg.y_low_nibble};
        moving      = (delta_x != '0) || (delta_y != '0);
        button_next = bmpt_pkg::decode_buttons(in_data_reg.status_byte[7:5]);
        if (moving)
        begin
            pos_x_next = bmpt_pkg::move_clamp(pos_x_reg, delta_x, x_min_reg, x_max_reg);
            pos_y_next = bmpt_pkg::move_clamp(pos_y_reg, delta_y, y_min_reg, y_max_reg);
        end
        else
        begin
            pos_x_next = pos_x_reg;
            pos_y_next = pos_y_reg;
        end
        out_data_next.x_pos       = pos_x_next;
        out_data_next.y_pos       = pos_y_next;
        out_data_next.button_code = button_next;
        out_data_next.changed     = moving || (button_next != last_buttons_reg);
    end

    // Hold valid flags and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pos_x_reg        <= bmpt_pkg::POS_RESET;
            pos_y_reg        <= bmpt_pkg::POS_RESET;
            last_buttons_reg <= bmpt_pkg::BTN_NONE;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                pos_x_reg        <= pos_x_next;
                pos_y_reg        <= pos_y_next;
                last_buttons_reg <= button_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= out_data_next;
    end

    // Write box registers; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= bmpt_pkg::X_MIN_RESET;
            x_max_reg <= bmpt_pkg::X_MAX_RESET;
            y_min_reg <= bmpt_pkg::Y_MIN_RESET;
            y_max_reg <= bmpt_pkg::Y_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bmpt_pkg::REG_X_MIN: x_min_reg <= cfg_data;
                bmpt_pkg::REG_X_MAX: x_max_reg <= cfg_data;
                bmpt_pkg::REG_Y_MIN: y_min_reg <= cfg_data;
                bmpt_pkg::REG_Y_MAX: y_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A processed request always lands in the result register
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not filled after advance");

    // No movement leaves the position alone
    a_still_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !moving |=> $stable(pos_x_reg) && $stable(pos_y_reg))
        else $error("position changed without movement");

    // Movement always flags a change
    a_move_flags_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance && moving |=> out_data_reg.changed)
        else $error("movement not flagged as changed");

    // A move with a sane X box stays inside it
    a_x_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        advance && moving && (x_min_reg <= x_max_reg) |=>
            (pos_x_reg >= $past(x_min_reg)) && (pos_x_reg <= $past(x_max_reg)))
        else $error("X position outside box after move");

    // Result register mirrors the tracked position
    a_out_matches_pos: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_data_reg.x_pos == pos_x_reg) && (out_data_reg.y_pos == pos_y_reg))
        else $error("result position differs from tracked position");

endmodule

// ----- tb/sv/bus_mouse_position_tracker_checker.sv -----
// Checker for the bus mouse position tracker: tracks the pointer position and compares results.
module bus_mouse_position_tracker_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  bmpt_pkg::in_item_t                 in_data,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  bmpt_pkg::out_item_t                out_data,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [bmpt_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [bmpt_pkg::PosWidth-1:0]      cfg_data,
    output int                                 mismatch_count,
    output int                                 pending_count
);

    logic [bmpt_pkg::PosWidth-1:0] box_x_lo;
    logic [bmpt_pkg::PosWidth-1:0] box_x_hi;
    logic [bmpt_pkg::PosWidth-1:0] box_y_lo;
    logic [bmpt_pkg::PosWidth-1:0] box_y_hi;
    logic [bmpt_pkg::PosWidth-1:0] cur_x;
    logic [bmpt_pkg::PosWidth-1:0] cur_y;
    bmpt_pkg::button_code_t        cur_btn;
    bmpt_pkg::out_item_t           expected_positions[$];
    bmpt_pkg::out_item_t           oldest;
    int                            fail_total = 0;

    // Move one axis by a signed delta, then clamp: minimum first, maximum last
    function automatic logic [bmpt_pkg::PosWidth-1:0] step_axis(
        input logic [bmpt_pkg::PosWidth-1:0]          pos,
        input logic signed [bmpt_pkg::DeltaWidth-1:0] delta,
        input logic [bmpt_pkg::PosWidth-1:0]          lo,
        input logic [bmpt_pkg::PosWidth-1:0]          hi
    );
        int v;
        v = int'(pos) + int'(delta);
        if (v < int'(lo))
            v = int'(lo);
        if (v > int'(hi))
            v = int'(hi);
        return v[bmpt_pkg::PosWidth-1:0];
    endfunction

    // Translate the raw status button field
    function automatic bmpt_pkg::button_code_t map_buttons(input logic [2:0] raw);
        bmpt_pkg::button_code_t code;
        case (raw)
            bmpt_pkg::RAW_LEFT:   code = bmpt_pkg::BTN_LEFT;
            bmpt_pkg::RAW_RIGHT:  code = bmpt_pkg::BTN_RIGHT;
            bmpt_pkg::RAW_MIDDLE: code = bmpt_pkg::BTN_MIDDLE;
            default:              code = bmpt_pkg::BTN_NONE;
        endcase
        return code;
    endfunction

    // Advance the tracked pointer by one sample and build its result
    function automatic bmpt_pkg::out_item_t track_sample(input bmpt_pkg::in_item_t s);
        logic signed [bmpt_pkg::DeltaWidth-1:0] dx;
        logic signed [bmpt_pkg::DeltaWidth-1:0] dy;
        bmpt_pkg::button_code_t                 btn;
        bmpt_pkg::out_item_t                    r;
        dx = {s.x_high_nibble, s.x_low_nibble};
        dy = {s.status_byte[3:0], s.y_low_nibble};
        btn = map_buttons(s.status_byte[7:5]);
        r.changed = 1'b0;
        // zero movement leaves the position alone, without clamping
        if (dx != 0 || dy != 0)
        begin
            cur_x = step_axis(cur_x, dx, box_x_lo, box_x_hi);
            cur_y = step_axis(cur_y, dy, box_y_lo, box_y_hi);
            r.changed = 1'b1;
        end
        if (btn != cur_btn)
            r.changed = 1'b1;
        cur_btn = btn;
        r.x_pos = cur_x;
        r.y_pos = cur_y;
        r.button_code = btn;
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_total++;
        end
    endtask

    // Watch all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_lo = bmpt_pkg::X_MIN_RESET;
            box_x_hi = bmpt_pkg::X_MAX_RESET;
            box_y_lo = bmpt_pkg::Y_MIN_RESET;
            box_y_hi = bmpt_pkg::Y_MAX_RESET;
            cur_x = bmpt_pkg::POS_RESET;
            cur_y = bmpt_pkg::POS_RESET;
            cur_btn = bmpt_pkg::BTN_NONE;
            expected_positions.delete();
            fail_total = 0;
        end
        else
        begin
            // apply register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bmpt_pkg::REG_X_MIN: box_x_lo = cfg_data;
                    bmpt_pkg::REG_X_MAX: box_x_hi = cfg_data;
                    bmpt_pkg::REG_Y_MIN: box_y_lo = cfg_data;
                    bmpt_pkg::REG_Y_MAX: box_y_hi = cfg_data;
                    default:             ;
                endcase
            end
            // compare the result with the oldest request
            if (out_valid && out_ready)
            begin
                if (expected_positions.size() == 0)
                begin
                    $display("%0t: result with no request, expected none, actual %0d/%0d/%0d/%0d",
                             $time, out_data.x_pos, out_data.y_pos, out_data.button_code,
                             out_data.changed);
                    fail_total++;
                end
                else
                begin
                    oldest = expected_positions.pop_front();
                    compare_field("x_pos", int'(oldest.x_pos), int'(out_data.x_pos));
                    compare_field("y_pos", int'(oldest.y_pos), int'(out_data.y_pos));
                    compare_field("button_code", int'(oldest.button_code),
                                  int'(out_data.button_code));
                    compare_field("changed", int'(oldest.changed), int'(out_data.changed));
                end
            end
            // predict each accepted request
            if (in_valid && in_ready)
                expected_positions.push_back(track_sample(in_data));
        end
        mismatch_count <= fail_total;
        pending_count <= expected_positions.size();
    end

endmodule

// ----- tb/sv/bus_mouse_position_tracker_core_test.sv -----
// Top of the bus mouse position tracker testbench: clock, reset, stimulus and verdict.
module bus_mouse_position_tracker_core_test;

    localparam int CycleLimit = 200000;

    // Raw button fields that decode to no button
    localparam logic [2:0] RAW_NONE_LO = 3'd3;
    localparam logic [2:0] RAW_NONE_HI = 3'd7;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    bmpt_pkg::in_item_t                 in_data = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    bmpt_pkg::out_item_t                out_data;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [bmpt_pkg::CfgIndexWidth-1:0] cfg_index = '0;
    logic [bmpt_pkg::PosWidth-1:0]      cfg_data = '0;
    int                                 mismatch_count;
    int                                 pending_count;
    int                                 send_idle_pct = 0;
    int                                 recv_stall_pct = 0;
    logic [2:0]                         last_raw = 3'd0;

    always #10 clk = ~clk;

    bus_mouse_position_tracker_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bus_mouse_position_tracker_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Stall the result channel at the current rate
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Pack deltas and button field into one bus sample
    function automatic bmpt_pkg::in_item_t make_sample(
        input logic [7:0] dx,
        input logic [7:0] dy,
        input logic [2:0] raw,
        input logic       spare
    );
        bmpt_pkg::in_item_t s;
        s.x_low_nibble = dx[3:0];
        s.x_high_nibble = dx[7:4];
        s.y_low_nibble = dy[3:0];
        s.status_byte = {raw, spare, dy[7:4]};
        return s;
    endfunction

    // Mostly small moves so the pointer wanders, some full-range jumps and rests
    function automatic bmpt_pkg::in_item_t random_sample();
        int         pick;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [2:0] raw;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            dx = 8'd0;
            dy = 8'd0;
        end
        else if (pick < 7)
        begin
            dx = 8'($urandom_range(0, 16)) - 8'd8;
            dy = 8'($urandom_range(0, 16)) - 8'd8;
        end
        else
        begin
            dx = 8'($urandom);
            dy = 8'($urandom);
        end
        // hold the button often so unchanged results show up
        raw = ($urandom_range(0, 2) == 0) ? last_raw : 3'($urandom);
        last_raw = raw;
        return make_sample(dx, dy, raw, 1'($urandom));
    endfunction

    // Offer one request, idling first at the current rate
    task automatic send_sample(input bmpt_pkg::in_item_t s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= s;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic cfg_write(
        input logic [bmpt_pkg::CfgIndexWidth-1:0] idx,
        input logic [bmpt_pkg::PosWidth-1:0]      value
    );
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_box(
        input logic [bmpt_pkg::PosWidth-1:0] xlo,
        input logic [bmpt_pkg::PosWidth-1:0] xhi,
        input logic [bmpt_pkg::PosWidth-1:0] ylo,
        input logic [bmpt_pkg::PosWidth-1:0] yhi
    );
        cfg_write(bmpt_pkg::REG_X_MIN, xlo);
        cfg_write(bmpt_pkg::REG_X_MAX, xhi);
        cfg_write(bmpt_pkg::REG_Y_MIN, ylo);
        cfg_write(bmpt_pkg::REG_Y_MAX, yhi);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop a hung run
    initial
    begin : watchdog
        repeat (CycleLimit) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int xlo;
        int ylo;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rest with no button, then button changes alone
        send_sample(make_sample(8'h00, 8'h00, RAW_NONE_LO, 1'b0));
        send_sample(make_sample(8'h00, 8'h00, bmpt_pkg::RAW_LEFT, 1'b0));
        // extreme deltas on each axis, every button code
        send_sample(make_sample(8'h7F, 8'h00, bmpt_pkg::RAW_LEFT, 1'b0));
        send_sample(make_sample(8'h80, 8'h7F, bmpt_pkg::RAW_RIGHT, 1'b0));
        send_sample(make_sample(8'h00, 8'h80, bmpt_pkg::RAW_MIDDLE, 1'b0));
        send_sample(make_sample(8'hFF, 8'hFF, RAW_NONE_HI, 1'b1));
        // push X into the right edge, then move while pinned there
        repeat (4) send_sample(make_sample(8'h7F, 8'h00, RAW_NONE_HI, 1'b0));
        // push Y into the top edge
        repeat (3) send_sample(make_sample(8'h00, 8'h80, RAW_NONE_HI, 1'b0));
        send_sample(make_sample(8'h00, 8'h00, RAW_NONE_HI, 1'b0));
        drain();

        // minimum above maximum on X; box moved away from the pointer on Y
        program_box(12'd500, 12'd100, 12'd4000, 12'd4095);
        send_sample(make_sample(8'h00, 8'h00, RAW_NONE_HI, 1'b0));
        send_sample(make_sample(8'h01, 8'h00, RAW_NONE_HI, 1'b0));
        send_sample(make_sample(8'h00, 8'h7F, bmpt_pkg::RAW_LEFT, 1'b0));
        drain();

        // unknown register indexes, then the full range
        cfg_write(8'd4, 12'd0);
        cfg_write(8'd255, 12'd4095);
        program_box(12'd0, 12'd4095, 12'd0, 12'd4095);
        send_sample(make_sample(8'h7F, 8'h00, bmpt_pkg::RAW_LEFT, 1'b0));
        send_sample(make_sample(8'h80, 8'h80, bmpt_pkg::RAW_RIGHT, 1'b1));
        drain();

        // single-point box at both ends of the range
        program_box(12'd4095, 12'd4095, 12'd0, 12'd0);
        send_sample(make_sample(8'h01, 8'h01, bmpt_pkg::RAW_MIDDLE, 1'b0));
        send_sample(make_sample(8'h80, 8'h7F, bmpt_pkg::RAW_MIDDLE, 1'b0));

        // random phases over idle patterns and box settings
        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 46;
                end
                default:
                begin
                    send_idle_pct = 12;
                    recv_stall_pct = 12;
                end
            endcase
            case (phase)
                0: program_box(12'd0, 12'd4095, 12'd0, 12'd4095);
                1: program_box(bmpt_pkg::X_MIN_RESET, bmpt_pkg::X_MAX_RESET,
                               bmpt_pkg::Y_MIN_RESET, bmpt_pkg::Y_MAX_RESET);
                2:
                begin
                    xlo = $urandom_range(0, 4095);
                    ylo = $urandom_range(0, 4095);
                    program_box(12'(xlo), 12'($urandom_range(xlo, 4095)),
                                12'(ylo), 12'($urandom_range(ylo, 4095)));
                end
                3:
                begin
                    xlo = $urandom_range(0, 4079);
                    ylo = $urandom_range(0, 4079);
                    program_box(12'(xlo), 12'(xlo + $urandom_range(0, 16)),
                                12'(ylo), 12'(ylo + $urandom_range(0, 16)));
                end
                4: program_box(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
                default:
                begin
                    cfg_write(8'($urandom_range(4, 255)), 12'($urandom));
                    xlo = $urandom_range(0, 2047);
                    ylo = $urandom_range(0, 2047);
                    program_box(12'(xlo), 12'($urandom_range(xlo, 4095)),
                                12'(ylo), 12'($urandom_range(ylo, 4095)));
                end
            endcase
            repeat (100) send_sample(random_sample());
        end

        drain();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
